// ----- sv/signed_integer_to_radix_ascii_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix ASCII conversion unit
// Shared property forms, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INTEGER_TO_RADIX_ASCII_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/sira_pkg.sv -----
// ----------------------------------------------------------------------------
// sira_pkg
// Types and constants shared by the radix ASCII conversion unit.
// ----------------------------------------------------------------------------
package sira_pkg;

    // Width of the signed input value.
    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [RADIX_W-1:0]           radix;
    } sira_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
    } sira_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic emit_sign;
        logic emit_digit;
    } sira_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic div_last;
        logic mag_zero;
        logic negative;
        logic cnt_one;
        logic out_free;
    } sira_stat_t;

    // Maps a digit value of 0 to 35 onto '0'-'9' then 'A'-'Z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] dec;
        dec = CHAR_ZERO + {2'b00, digit};
        if (dec <= CHAR_NINE) begin
            return dec;
        end
        return dec + (CHAR_UPPER_A - CHAR_NINE - 8'd1);
    endfunction

endpackage

// ----- sv/sira_ctrl.sv -----
// ----------------------------------------------------------------------------
// sira_ctrl
// Sequencer for the conversion: division passes, digit stores and emission.
// ----------------------------------------------------------------------------
module sira_ctrl
    import sira_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sira_stat_t stat,
    output sira_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_STORE = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EMIT  = 6'b100000
    } sira_state_t;

    sira_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (!stat.mag_zero) begin
                    state_next = ST_DIV;
                end else if (stat.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_SIGN: begin
                if (stat.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                // The digit memory read completes during this cycle.
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_digit = 1'b1;
                    state_next     = stat.cnt_one ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/sira_datapath.sv -----
// ----------------------------------------------------------------------------
// sira_datapath
// Restoring radix divider, digit memory and output word register.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_ascii_unit_defines.svh"

module sira_datapath
    import sira_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  sira_in_t   s_data,
    input  sira_cmd_t  cmd,
    output sira_stat_t stat,
    output logic       m_valid,
    input  logic       m_ready,
    output sira_out_t  m_data
);

    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W = $clog2(VALUE_BITS);
    localparam int STEP_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;
    sira_out_t             m_data_reg, m_data_next;

    logic [DIGIT_W-1:0]    mem [VALUE_BITS];
    logic [DIGIT_W-1:0]    rd_data_reg;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [CNT_W-1:0]      cnt_minus_one;

    logic [DIGIT_W:0]      trial;
    logic                  trial_ge;
    logic [VALUE_BITS-1:0] in_bits;
    logic                  out_free;

    assign in_bits       = s_data.value;
    assign out_free      = !m_valid_reg || m_ready;
    assign cnt_minus_one = cnt_reg - CNT_W'(1);
    assign wr_addr       = cnt_reg[ADDR_W-1:0];
    assign rd_addr       = cnt_minus_one[ADDR_W-1:0];

    // One restoring step: shift the next magnitude bit into the partial
    // remainder and subtract the radix when it fits.
    assign trial    = {rem_reg, mag_reg[VALUE_BITS-1]};
    assign trial_ge = (trial >= {1'b0, radix_reg});

    always_comb begin
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        step_next    = step_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            neg_next  = in_bits[VALUE_BITS-1];
            mag_next  = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;
            rem_next  = '0;
            cnt_next  = '0;
            step_next = '0;
            if (s_data.radix < RADIX_MIN) begin
                radix_next = RADIX_MIN;
            end else if (s_data.radix > RADIX_MAX) begin
                radix_next = RADIX_MAX;
            end else begin
                radix_next = s_data.radix;
            end
        end

        if (cmd.div_step) begin
            mag_next  = {mag_reg[VALUE_BITS-2:0], trial_ge};
            rem_next  = trial_ge ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
        end

        if (cmd.store) begin
            cnt_next  = cnt_reg + CNT_W'(1);
            rem_next  = '0;
            step_next = '0;
        end

        if (cmd.emit_sign) begin
            m_data_next.out_char  = CHAR_MINUS;
            m_data_next.last_char = 1'b0;
            m_valid_next          = 1'b1;
        end

        if (cmd.emit_digit) begin
            m_data_next.out_char  = digit_to_ascii(rd_data_reg);
            m_data_next.last_char = (cnt_reg == CNT_W'(1));
            m_valid_next          = 1'b1;
            cnt_next              = cnt_minus_one;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            step_reg    <= '0;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        m_data_reg <= m_data_next;
    end

    // Digit memory: written once per digit, read one entry per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            mem[wr_addr] <= rem_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign stat.div_last = (step_reg == STEP_W'(VALUE_BITS - 1));
    assign stat.mag_zero = (mag_reg == '0);
    assign stat.negative = neg_reg;
    assign stat.cnt_one  = (cnt_reg == CNT_W'(1));
    assign stat.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SIRA_ASSERT_SAME(a_store_in_range, cmd.store, cnt_reg < CNT_W'(VALUE_BITS),
        "digit store beyond memory depth")
    `SIRA_ASSERT_SAME(a_rem_below_radix, cmd.store, rem_reg < radix_reg,
        "stored digit not below radix")
    `SIRA_ASSERT_SAME(a_radix_clamped, cmd.div_step,
        (radix_reg >= RADIX_MIN) && (radix_reg <= RADIX_MAX), "radix out of range")
    `SIRA_ASSERT_NEXT(a_last_empties, cmd.emit_digit && stat.cnt_one,
        (cnt_reg == '0) && m_data.last_char, "last digit did not empty the count")

endmodule

// ----- sv/signed_integer_to_radix_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_ascii_unit
// Converts a signed integer into ASCII digits in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_data) takes one word holding a
// signed value and a radix. A radix below 2 is used as 2 and one above 36
// as 36. The result channel (m_valid, m_ready, m_data) returns one word per
// character, most significant first: a '-' for a negative value, then the
// digits '0'-'9' and 'A'-'Z'. The last character of a number carries
// last_char. Zero gives the single character "0".
// Each digit costs one restoring division by the radix, one quotient bit per
// cycle over the full value width, then a store of the digit. Each
// character is emitted after a registered read of the digit memory, and
// a negative number emits its sign before the digits. The longest number
// is 32 binary digits and a sign.
// The next word is taken once the last character has gone into the output
// register, even while that character still waits for m_ready.
// A stalled receiver holds the current character and pauses the emitter.
// After reset the unit is idle, the output is empty and s_ready is high.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_ascii_unit
    import sira_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sira_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sira_out_t m_data
);

    // Commands and status between the sequencer and the datapath.
    sira_cmd_t  cmd;
    sira_stat_t stat;

    // The sequencer steps through the division passes, the digit stores and
    // the emission of the sign and the digits.
    sira_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the magnitude, the shared divider, the digit memory
    // and the output register that decouples the receiver.
    sira_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to radix ASCII unit.
// Every word sent in is converted by a behavioral predictor into the string
// of characters it must produce. Each character that leaves the unit is
// compared with the oldest prediction. The stimulus covers the value
// extremes, clamped radices, a long receiver hold-off and random traffic,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb
    import sira_pkg::*;
();

    localparam logic signed [VALUE_BITS-1:0] VALUE_MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MOST_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // The limit covers the slowest word, the receiver hold-off below and
    // idle bursts, several times over.
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int HOLDOFF_CYCLES    = 3000;
    // Once nothing is outstanding, wait about one worst-case conversion so
    // that a stray character would still be caught.
    localparam int END_SETTLE_CYCLES = 1200;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    sira_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    sira_out_t m_data;

    // Characters still owed by the unit, oldest first.
    sira_out_t expected_chars[$];
    int        mismatch_count;
    int        stall_free_cycles;
    // Random idling on both channels; cleared for the last part of the run.
    bit        idle_enable;
    // A long receiver hold-off requested by a test; the receiver takes it.
    int        rx_holdoff_request;

    signed_integer_to_radix_ascii_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the characters for one word: the magnitude is taken as an
    // unsigned number, so the most negative value converts like any other.
    function automatic void predict_chars(input sira_in_t w);
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_W-1:0]    base;
        logic [DIGIT_W-1:0]    digits[$];
        sira_out_t             ch;
        base = (w.radix < RADIX_MIN) ? RADIX_MIN :
               (w.radix > RADIX_MAX) ? RADIX_MAX : w.radix;
        mag = w.value;
        if (w.value[VALUE_BITS-1]) begin
            mag = ~mag + 1'b1;
            ch.out_char  = CHAR_MINUS;
            ch.last_char = 1'b0;
            expected_chars.push_back(ch);
        end
        // Zero still yields one digit.
        do begin
            digits.push_front(DIGIT_W'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        foreach (digits[i]) begin
            ch.out_char  = (digits[i] < 10) ? CHAR_ZERO + 8'(digits[i])
                                            : CHAR_UPPER_A + 8'(digits[i]) - 8'd10;
            ch.last_char = (i == digits.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                   input logic [CHAR_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_char(input sira_out_t got);
        sira_out_t want;
        if (expected_chars.size() == 0) begin
            report_mismatch("unexpected character", got.out_char, 8'h00);
            return;
        end
        want = expected_chars.pop_front();
        if (got.out_char !== want.out_char)
            report_mismatch("out_char", got.out_char, want.out_char);
        if (got.last_char !== want.last_char)
            report_mismatch("last_char", 8'(got.last_char), 8'(want.last_char));
    endtask

    // Every character accepted by the receiver is checked at the edge that
    // takes it; values sampled here are the ones from before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_char(m_data);
    end

    // The watchdog ends a run in which no word moves on either channel for
    // too long, which covers a hung unit and missing characters alike.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_free_cycles <= 0;
        end else if (stall_free_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_free_cycles <= stall_free_cycles + 1;
        end
    end

    // Receiver: sets m_ready at random, mostly ready, and holds it for a burst,
    // takes a long hold-off when a test asks for one, and is always ready once
    // idling is switched off. Each pass assigns m_ready once and then waits on
    // a clock edge before the next pass.
    initial begin
        int n;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_holdoff_request > 0) begin
                n = rx_holdoff_request;
                rx_holdoff_request = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (!idle_enable) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Offers one word and holds it until accepted. Valid stays high when no
    // idle burst follows, so the next word can go out on the very next edge.
    task automatic send_word(input logic signed [VALUE_BITS-1:0] value,
                             input logic [RADIX_W-1:0] radix);
        sira_in_t w;
        w.value = value;
        w.radix = radix;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_chars(w);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // The sender pauses until every owed character has come back. It always
    // waits on a clock edge before returning, so that valid is never lowered
    // and raised in the same step.
    task automatic wait_all_chars();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
    endtask

    // Random radix: mostly in range, sometimes anywhere in the 6-bit field
    // so that the clamping is exercised and every radix bit toggles.
    function automatic logic [RADIX_W-1:0] random_radix();
        if ($urandom_range(0, 9) == 0)
            return RADIX_W'($urandom_range(0, 63));
        return RADIX_W'($urandom_range(2, 36));
    endfunction

    // Random value with a spread of magnitudes: full range, small numbers of
    // both signs, powers of the radix and their neighbors (where the digit
    // count changes), values next to the extremes, and random widths.
    function automatic logic signed [VALUE_BITS-1:0] random_value(input logic [RADIX_W-1:0] radix);
        longint unsigned              power;
        int unsigned                  steps;
        logic [RADIX_W-1:0]           base;
        logic signed [VALUE_BITS-1:0] v;
        base = (radix < RADIX_MIN) ? RADIX_MIN : (radix > RADIX_MAX) ? RADIX_MAX : radix;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 100);
            2: v = 0 - $urandom_range(1, 100);
            3: begin
                power = 1;
                steps = $urandom_range(1, 31);
                repeat (steps) begin
                    if (power * base <= 64'h7FFF_FFFF)
                        power = power * base;
                end
                v = VALUE_BITS'(power + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4: v = $urandom_range(0, 1) ? VALUE_MOST_NEG + $urandom_range(0, 3)
                                        : VALUE_MOST_POS - $urandom_range(0, 3);
            default: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Field extremes, both ends of the radix range, clamped radices, zero,
    // the most negative value, and the digits on either side of '9'/'A'.
    task automatic test_directed_extremes();
        send_word(0, 6'd10);
        send_word(0, 6'd2);
        send_word(1, 6'd10);
        send_word(-1, 6'd10);
        send_word(-1, 6'd2);
        send_word(VALUE_MOST_POS, 6'd2);
        send_word(VALUE_MOST_POS, 6'd10);
        send_word(VALUE_MOST_POS, 6'd36);
        send_word(VALUE_MOST_NEG, 6'd2);
        send_word(VALUE_MOST_NEG, 6'd10);
        send_word(VALUE_MOST_NEG, 6'd16);
        send_word(VALUE_MOST_NEG, 6'd36);
        send_word(9, 6'd11);
        send_word(10, 6'd11);
        send_word(35, 6'd36);
        send_word(-35, 6'd36);
        send_word(255, 6'd16);
        // Radices outside 2..36, including an all-zero and an all-one field.
        send_word(12345, 6'd0);
        send_word(-12345, 6'd1);
        send_word(123456789, 6'd37);
        send_word(-123456789, 6'd63);
        send_word(32'h5555_5555, 6'd3);
        send_word(32'hAAAA_AAAA, 6'd7);
        wait_all_chars();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // long words, so the output register fills and s_ready drops.
    task automatic test_receiver_holdoff();
        rx_holdoff_request = HOLDOFF_CYCLES;
        repeat (8) send_word(random_value(6'd2) | VALUE_MOST_NEG, RADIX_W'($urandom_range(2, 4)));
        wait_all_chars();
    endtask

    // Random words with idling on both sides; every so often the sender
    // waits for the unit to drain before going on.
    task automatic test_random_traffic(input int count);
        logic [RADIX_W-1:0] radix;
        repeat (count) begin
            radix = random_radix();
            send_word(random_value(radix), radix);
            if ($urandom_range(0, 39) == 0)
                wait_all_chars();
        end
        wait_all_chars();
    endtask

    // Back-to-back traffic with no idling anywhere at the end of the run.
    task automatic test_full_rate(input int count);
        idle_enable = 1'b0;
        test_random_traffic(count);
    endtask

    initial begin
        mismatch_count     = 0;
        stall_free_cycles  = 0;
        idle_enable        = 1'b1;
        rx_holdoff_request = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_receiver_holdoff();
        test_random_traffic(190);
        test_full_rate(60);

        s_valid <= 1'b0;
        repeat (END_SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
